// ===== rtl/core/vcsl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsl_pkg
// Types, constants and the microcode table shared by the slew limiter files.
// ----------------------------------------------------------------------------
package vcsl_pkg;

  localparam int unsigned VEL_W  = 16;   // velocity fields, two's complement
  localparam int unsigned LIM_W  = 15;   // speed limits
  localparam int unsigned ACC_W  = 16;   // acceleration limits
  localparam int unsigned DT_W   = 16;   // time step
  localparam int unsigned IDX_W  = 3;    // configuration register index
  localparam int unsigned CFG_DW = 16;   // configuration write data
  localparam int unsigned PC_W   = 5;    // microcode step counter
  localparam int unsigned SQ_W   = 2 * LIM_W;      // square of a limit
  localparam int unsigned MUL_AW = 16;             // multiplier operand A
  localparam int unsigned MUL_BW = SQ_W;           // multiplier operand B
  localparam int unsigned PROD_W = MUL_AW + MUL_BW;
  localparam int unsigned Q_W    = LIM_W;          // decoupling quotient
  localparam int unsigned CNT_W  = 4;

  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(Q_W);

  localparam logic [VEL_W-1:0] MIN_DV           = 16'd10;
  localparam logic [VEL_W-1:0] FORWARD_DEADBAND = 16'd10;
  localparam logic [VEL_W-1:0] SIDE_DEADBAND    = 16'd10;
  localparam logic [VEL_W-1:0] YAW_DEADBAND     = 16'd10;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_MAX_FORWARD = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_SIDE    = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX_YAW     = 3'd2;
  localparam logic [IDX_W-1:0] REG_FWD_ACCEL   = 3'd3;
  localparam logic [IDX_W-1:0] REG_SIDE_ACCEL  = 3'd4;
  localparam logic [IDX_W-1:0] REG_YAW_ACCEL   = 3'd5;
  localparam logic [IDX_W-1:0] REG_DECOUPLE    = 3'd6;

  // Micro-operations of the datapath.
  typedef logic [3:0] uop_t;
  localparam uop_t UOP_NOP      = 4'd0;
  localparam uop_t UOP_IDLE     = 4'd1;
  localparam uop_t UOP_CLAMP    = 4'd2;
  localparam uop_t UOP_MUL_MM   = 4'd3;
  localparam uop_t UOP_MUL_YY   = 4'd4;
  localparam uop_t UOP_SUB      = 4'd5;
  localparam uop_t UOP_MUL_SD   = 4'd6;
  localparam uop_t UOP_DIV_INIT = 4'd7;
  localparam uop_t UOP_DIV_STEP = 4'd8;
  localparam uop_t UOP_DIV_DONE = 4'd9;
  localparam uop_t UOP_MUL_AD   = 4'd10;
  localparam uop_t UOP_SLEW1    = 4'd11;
  localparam uop_t UOP_SLEW2    = 4'd12;
  localparam uop_t UOP_FINISH   = 4'd13;

  typedef logic [1:0] axis_t;
  localparam axis_t AX_FWD  = 2'd0;
  localparam axis_t AX_SIDE = 2'd1;
  localparam axis_t AX_YAW  = 2'd2;

  // Jump conditions.
  typedef logic [2:0] cond_t;
  localparam cond_t COND_NEVER    = 3'd0;
  localparam cond_t COND_ALWAYS   = 3'd1;
  localparam cond_t COND_NO_IN    = 3'd2;
  localparam cond_t COND_NO_DEC   = 3'd3;
  localparam cond_t COND_PASS     = 3'd4;
  localparam cond_t COND_DIV_MORE = 3'd5;
  localparam cond_t COND_OUT_FULL = 3'd6;

  typedef logic [PC_W-1:0] pc_t;
  localparam pc_t ST_IDLE   = 5'd0;
  localparam pc_t ST_DIV    = 5'd9;
  localparam pc_t ST_SLEW   = 5'd11;
  localparam pc_t ST_FINISH = 5'd20;

  typedef struct packed {
    uop_t  op;
    axis_t axis;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    uop_t  op;
    axis_t axis;
  } ctrl_t;

  typedef struct packed {
    logic no_input;
    logic no_decouple;
    logic pass;
    logic div_more;
    logic out_full;
  } stat_t;

  typedef struct packed {
    logic [LIM_W-1:0] max_forward;
    logic [LIM_W-1:0] max_side;
    logic [LIM_W-1:0] max_yaw;
    logic [ACC_W-1:0] fwd_accel;
    logic [ACC_W-1:0] side_accel;
    logic [ACC_W-1:0] yaw_accel;
    logic             decouple;
  } cfg_t;

  // The control program. A step whose condition holds jumps to its target,
  // otherwise the step counter advances by one.
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    case (pc)
      5'd0:    w = '{UOP_IDLE,     AX_FWD,  COND_NO_IN,    ST_IDLE};
      5'd1:    w = '{UOP_CLAMP,    AX_FWD,  COND_NEVER,    ST_IDLE};
      5'd2:    w = '{UOP_CLAMP,    AX_SIDE, COND_NEVER,    ST_IDLE};
      5'd3:    w = '{UOP_CLAMP,    AX_YAW,  COND_NO_DEC,   ST_SLEW};
      5'd4:    w = '{UOP_MUL_MM,   AX_YAW,  COND_NEVER,    ST_IDLE};
      5'd5:    w = '{UOP_MUL_YY,   AX_YAW,  COND_NEVER,    ST_IDLE};
      5'd6:    w = '{UOP_SUB,      AX_YAW,  COND_NEVER,    ST_IDLE};
      5'd7:    w = '{UOP_MUL_SD,   AX_SIDE, COND_NEVER,    ST_IDLE};
      5'd8:    w = '{UOP_DIV_INIT, AX_SIDE, COND_NEVER,    ST_IDLE};
      5'd9:    w = '{UOP_DIV_STEP, AX_SIDE, COND_DIV_MORE, ST_DIV};
      5'd10:   w = '{UOP_DIV_DONE, AX_SIDE, COND_NEVER,    ST_IDLE};
      5'd11:   w = '{UOP_MUL_AD,   AX_FWD,  COND_PASS,     ST_FINISH};
      5'd12:   w = '{UOP_SLEW1,    AX_FWD,  COND_NEVER,    ST_IDLE};
      5'd13:   w = '{UOP_SLEW2,    AX_FWD,  COND_NEVER,    ST_IDLE};
      5'd14:   w = '{UOP_MUL_AD,   AX_SIDE, COND_NEVER,    ST_IDLE};
      5'd15:   w = '{UOP_SLEW1,    AX_SIDE, COND_NEVER,    ST_IDLE};
      5'd16:   w = '{UOP_SLEW2,    AX_SIDE, COND_NEVER,    ST_IDLE};
      5'd17:   w = '{UOP_MUL_AD,   AX_YAW,  COND_NEVER,    ST_IDLE};
      5'd18:   w = '{UOP_SLEW1,    AX_YAW,  COND_NEVER,    ST_IDLE};
      5'd19:   w = '{UOP_SLEW2,    AX_YAW,  COND_NEVER,    ST_IDLE};
      5'd20:   w = '{UOP_FINISH,   AX_FWD,  COND_OUT_FULL, ST_FINISH};
      default: w = '{UOP_NOP,      AX_FWD,  COND_ALWAYS,   ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/vcsl_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsl_in_if
// Velocity target channel: three axis targets, time step and restart flag.
// ----------------------------------------------------------------------------
interface vcsl_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [vcsl_pkg::VEL_W-1:0]   target_forward;
  logic signed [vcsl_pkg::VEL_W-1:0]   target_side;
  logic signed [vcsl_pkg::VEL_W-1:0]   target_yaw;
  logic        [vcsl_pkg::DT_W-1:0]    step_time;
  logic                                restart;

  modport source (
    output valid, target_forward, target_side, target_yaw, step_time, restart,
    input  ready
  );
  modport sink (
    input  valid, target_forward, target_side, target_yaw, step_time, restart,
    output ready
  );
endinterface

// ===== rtl/core/vcsl_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsl_out_if
// Smoothed velocity command channel.
// ----------------------------------------------------------------------------
interface vcsl_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [vcsl_pkg::VEL_W-1:0] out_forward;
  logic signed [vcsl_pkg::VEL_W-1:0] out_side;
  logic signed [vcsl_pkg::VEL_W-1:0] out_yaw;

  modport source (output valid, out_forward, out_side, out_yaw, input ready);
  modport sink   (input  valid, out_forward, out_side, out_yaw, output ready);
endinterface

// ===== rtl/core/vcsl_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsl_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface vcsl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [vcsl_pkg::IDX_W-1:0]    reg_index;
  logic [vcsl_pkg::CFG_DW-1:0]   wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input  valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/core/vcsl_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsl_cfg_regs
// Limit and acceleration registers, written through the configuration port.
// ----------------------------------------------------------------------------
module vcsl_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  vcsl_cfg_if.sink        cfg_ch,
  output vcsl_pkg::cfg_t  cfg
);

  vcsl_pkg::cfg_t cfg_r;
  logic           wr_en;

  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_forward <= 15'd1024;
      cfg_r.max_side    <= 15'd512;
      cfg_r.max_yaw     <= 15'd1024;
      cfg_r.fwd_accel   <= 16'd1024;
      cfg_r.side_accel  <= 16'd1024;
      cfg_r.yaw_accel   <= 16'd1024;
      cfg_r.decouple    <= 1'b1;
    end else if (wr_en) begin
      case (cfg_ch.reg_index)
        vcsl_pkg::REG_MAX_FORWARD: cfg_r.max_forward <= cfg_ch.wdata[vcsl_pkg::LIM_W-1:0];
        vcsl_pkg::REG_MAX_SIDE:    cfg_r.max_side    <= cfg_ch.wdata[vcsl_pkg::LIM_W-1:0];
        vcsl_pkg::REG_MAX_YAW:     cfg_r.max_yaw     <= cfg_ch.wdata[vcsl_pkg::LIM_W-1:0];
        vcsl_pkg::REG_FWD_ACCEL:   cfg_r.fwd_accel   <= cfg_ch.wdata[vcsl_pkg::ACC_W-1:0];
        vcsl_pkg::REG_SIDE_ACCEL:  cfg_r.side_accel  <= cfg_ch.wdata[vcsl_pkg::ACC_W-1:0];
        vcsl_pkg::REG_YAW_ACCEL:   cfg_r.yaw_accel   <= cfg_ch.wdata[vcsl_pkg::ACC_W-1:0];
        vcsl_pkg::REG_DECOUPLE:    cfg_r.decouple    <= cfg_ch.wdata[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/vcsl_useq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsl_useq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module vcsl_useq (
  input  logic             clk,
  input  logic             rst_n,
  input  vcsl_pkg::stat_t  stat,
  output vcsl_pkg::ctrl_t  ctrl
);

  vcsl_pkg::pc_t    pc_r;
  vcsl_pkg::pc_t    pc_nxt;
  vcsl_pkg::ucode_t word;
  logic             take_jump;

  assign word      = vcsl_pkg::ucode_rom(pc_r);
  assign ctrl.op   = word.op;
  assign ctrl.axis = word.axis;

  always_comb begin
    case (word.cond)
      vcsl_pkg::COND_NEVER:    take_jump = 1'b0;
      vcsl_pkg::COND_ALWAYS:   take_jump = 1'b1;
      vcsl_pkg::COND_NO_IN:    take_jump = stat.no_input;
      vcsl_pkg::COND_NO_DEC:   take_jump = stat.no_decouple;
      vcsl_pkg::COND_PASS:     take_jump = stat.pass;
      vcsl_pkg::COND_DIV_MORE: take_jump = stat.div_more;
      vcsl_pkg::COND_OUT_FULL: take_jump = stat.out_full;
      default:                 take_jump = 1'b1;
    endcase
    pc_nxt = take_jump ? word.target : pc_r + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= vcsl_pkg::ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== rtl/core/vcsl_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsl_datapath
// Axis registers, shared multiplier, restoring divider step, slew and clamp
// logic and the output register, all steered by the microcode.
// ----------------------------------------------------------------------------
module vcsl_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  vcsl_pkg::cfg_t   cfg,
  input  vcsl_pkg::ctrl_t  ctrl,
  output vcsl_pkg::stat_t  stat,
  vcsl_in_if.sink          in_ch,
  vcsl_out_if.source       out_ch
);

  localparam int unsigned VW = vcsl_pkg::VEL_W;

  logic signed [VW-1:0]                  tgt_r  [3];
  logic signed [VW-1:0]                  prev_r [3];
  logic [vcsl_pkg::DT_W-1:0]             dt_r;
  logic                                  restart_r;
  logic                                  first_r;
  logic [vcsl_pkg::PROD_W-1:0]           prod_r;
  logic [vcsl_pkg::SQ_W-1:0]             m2_r;
  logic [vcsl_pkg::SQ_W-1:0]             diff_r;
  logic [vcsl_pkg::SQ_W-1:0]             rem_r;
  logic [vcsl_pkg::Q_W-1:0]              dq_r;
  logic [vcsl_pkg::CNT_W-1:0]            cnt_r;
  logic signed [VW:0]                    step_r;
  logic signed [VW-1:0]                  out_fwd_r;
  logic signed [VW-1:0]                  out_side_r;
  logic signed [VW-1:0]                  out_yaw_r;
  logic                                  out_valid_r;

  logic signed [VW-1:0]                  cur_tgt;
  logic signed [VW-1:0]                  cur_prev;
  logic [vcsl_pkg::LIM_W-1:0]            cur_lim;
  logic [vcsl_pkg::ACC_W-1:0]            cur_acc;
  logic [vcsl_pkg::MUL_AW-1:0]           mul_a;
  logic [vcsl_pkg::MUL_BW-1:0]           mul_b;
  logic                                  mul_en;
  logic                                  accept;
  logic                                  finish;
  logic [vcsl_pkg::SQ_W:0]               div_trial;
  logic                                  div_bit;
  logic [VW-1:0]                         dv;
  logic signed [VW:0]                    delta;
  logic signed [VW:0]                    dv_s;
  logic signed [VW:0]                    step_nxt;
  logic signed [VW+1:0]                  slew_sum;
  logic [vcsl_pkg::Q_W:0]                q_ext;

  function automatic logic signed [VW-1:0] clamp_sym(input logic signed [VW+1:0] v,
                                                      input logic [vcsl_pkg::LIM_W-1:0] lim);
    logic signed [VW+1:0] hi;
    logic signed [VW+1:0] lo;
    logic signed [VW+1:0] r;
    hi = signed'((VW+2)'(lim));
    lo = -hi;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[VW-1:0];
  endfunction

  // Clamped values never reach the most negative code, so the magnitude fits.
  function automatic logic [vcsl_pkg::LIM_W-1:0] mag15(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] m;
    m = v[VW-1] ? -v : v;
    return m[vcsl_pkg::LIM_W-1:0];
  endfunction

  function automatic logic signed [VW-1:0] deadband(input logic signed [VW-1:0] v,
                                                     input logic [VW-1:0] band);
    logic signed [VW-1:0] m;
    m = v[VW-1] ? -v : v;
    return (unsigned'(m) < band) ? '0 : v;
  endfunction

  assign cur_tgt  = tgt_r[ctrl.axis];
  assign cur_prev = prev_r[ctrl.axis];

  always_comb begin
    case (ctrl.axis)
      vcsl_pkg::AX_FWD:  begin cur_lim = cfg.max_forward; cur_acc = cfg.fwd_accel;  end
      vcsl_pkg::AX_SIDE: begin cur_lim = cfg.max_side;    cur_acc = cfg.side_accel; end
      vcsl_pkg::AX_YAW:  begin cur_lim = cfg.max_yaw;     cur_acc = cfg.yaw_accel;  end
      default:           begin cur_lim = cfg.max_forward; cur_acc = cfg.fwd_accel;  end
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_en = 1'b1;
    case (ctrl.op)
      vcsl_pkg::UOP_MUL_MM: begin
        mul_a = vcsl_pkg::MUL_AW'(cfg.max_yaw);
        mul_b = vcsl_pkg::MUL_BW'(cfg.max_yaw);
      end
      vcsl_pkg::UOP_MUL_YY: begin
        mul_a = vcsl_pkg::MUL_AW'(mag15(tgt_r[vcsl_pkg::AX_YAW]));
        mul_b = vcsl_pkg::MUL_BW'(mag15(tgt_r[vcsl_pkg::AX_YAW]));
      end
      vcsl_pkg::UOP_MUL_SD: begin
        mul_a = vcsl_pkg::MUL_AW'(mag15(tgt_r[vcsl_pkg::AX_SIDE]));
        mul_b = diff_r;
      end
      vcsl_pkg::UOP_MUL_AD: begin
        mul_a = cur_acc;
        mul_b = vcsl_pkg::MUL_BW'(dt_r);
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
  end

  // One restoring division step: the remainder is always below the divisor.
  assign div_trial = {rem_r, dq_r[vcsl_pkg::Q_W-1]};
  assign div_bit   = (div_trial >= {1'b0, m2_r});
  assign q_ext     = {1'b0, dq_r};

  // Step toward the target, limited to the larger of accel*dt and the floor.
  assign dv       = (prod_r[VW+15:16] < vcsl_pkg::MIN_DV) ? vcsl_pkg::MIN_DV
                                                           : prod_r[VW+15:16];
  assign delta    = {cur_tgt[VW-1], cur_tgt} - {cur_prev[VW-1], cur_prev};
  assign dv_s     = signed'({1'b0, dv});
  assign step_nxt = (delta > dv_s) ? dv_s : ((delta < -dv_s) ? -dv_s : delta);
  assign slew_sum = {{2{cur_prev[VW-1]}}, cur_prev} + {step_r[VW], step_r};

  assign accept = in_ch.valid && (ctrl.op == vcsl_pkg::UOP_IDLE);
  assign finish = (ctrl.op == vcsl_pkg::UOP_FINISH) && !stat.out_full;

  assign in_ch.ready        = (ctrl.op == vcsl_pkg::UOP_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_forward = out_fwd_r;
  assign out_ch.out_side    = out_side_r;
  assign out_ch.out_yaw     = out_yaw_r;

  assign stat.no_input    = !in_ch.valid;
  assign stat.no_decouple = !(cfg.decouple && (cfg.max_yaw > 15'd1));
  assign stat.pass        = first_r || restart_r || (dt_r == '0);
  assign stat.div_more    = (cnt_r != 4'd1);
  assign stat.out_full    = out_valid_r && !out_ch.ready;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      for (int i = 0; i < 3; i++) begin
        prev_r[i] <= '0;
      end
    end else begin
      if (finish) begin
        first_r     <= 1'b0;
        out_valid_r <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          prev_r[i] <= tgt_r[i];
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (ctrl.op == vcsl_pkg::UOP_DIV_INIT) begin
        cnt_r <= vcsl_pkg::DIV_STEPS;
      end else if (ctrl.op == vcsl_pkg::UOP_DIV_STEP) begin
        cnt_r <= cnt_r - 4'd1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= vcsl_pkg::PROD_W'(mul_a) * vcsl_pkg::PROD_W'(mul_b);
    end
    if (accept) begin
      tgt_r[vcsl_pkg::AX_FWD]  <= in_ch.target_forward;
      tgt_r[vcsl_pkg::AX_SIDE] <= in_ch.target_side;
      tgt_r[vcsl_pkg::AX_YAW]  <= in_ch.target_yaw;
      dt_r                     <= in_ch.step_time;
      restart_r                <= in_ch.restart;
    end
    case (ctrl.op)
      vcsl_pkg::UOP_CLAMP: begin
        tgt_r[ctrl.axis] <= clamp_sym({{2{cur_tgt[VW-1]}}, cur_tgt}, cur_lim);
      end
      vcsl_pkg::UOP_MUL_YY: begin
        m2_r <= prod_r[vcsl_pkg::SQ_W-1:0];
      end
      vcsl_pkg::UOP_SUB: begin
        diff_r <= m2_r - prod_r[vcsl_pkg::SQ_W-1:0];
      end
      vcsl_pkg::UOP_DIV_INIT: begin
        // The quotient never exceeds the lateral magnitude, so the top bits
        // of the product already sit below the divisor.
        rem_r <= prod_r[vcsl_pkg::Q_W +: vcsl_pkg::SQ_W];
        dq_r  <= prod_r[vcsl_pkg::Q_W-1:0];
      end
      vcsl_pkg::UOP_DIV_STEP: begin
        rem_r <= div_bit ? vcsl_pkg::SQ_W'(div_trial - {1'b0, m2_r})
                         : div_trial[vcsl_pkg::SQ_W-1:0];
        dq_r  <= {dq_r[vcsl_pkg::Q_W-2:0], div_bit};
      end
      vcsl_pkg::UOP_DIV_DONE: begin
        tgt_r[vcsl_pkg::AX_SIDE] <= tgt_r[vcsl_pkg::AX_SIDE][VW-1]
                                    ? -signed'(q_ext) : signed'(q_ext);
      end
      vcsl_pkg::UOP_SLEW1: begin
        step_r <= step_nxt;
      end
      vcsl_pkg::UOP_SLEW2: begin
        tgt_r[ctrl.axis] <= clamp_sym(slew_sum, cur_lim);
      end
      default: ;
    endcase
    if (finish) begin
      out_fwd_r  <= deadband(tgt_r[vcsl_pkg::AX_FWD],  vcsl_pkg::FORWARD_DEADBAND);
      out_side_r <= deadband(tgt_r[vcsl_pkg::AX_SIDE], vcsl_pkg::SIDE_DEADBAND);
      out_yaw_r  <= deadband(tgt_r[vcsl_pkg::AX_YAW],  vcsl_pkg::YAW_DEADBAND);
    end
  end

endmodule

// ===== rtl/core/velocity_command_slew_limiter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_command_slew_limiter
// Three-axis velocity command slew limiter with lateral decoupling.
// ----------------------------------------------------------------------------
// Takes one velocity target beat at a time and returns one smoothed command
// beat for it. A beat that passes straight through (first beat after reset,
// restart set, or a zero time step) skips the slew steps; decoupling adds the
// multiply, subtract and divide steps. The next beat is accepted only after
// the result register is loaded, which waits while a previous result is held
// and out_ch.ready is low. The block runs a microcoded sequence over one shared
// multiplier, with the lateral decoupling division done by a 15-step restoring
// divider. Configuration writes are taken in every cycle and must only be
// issued while the block is idle.
module velocity_command_slew_limiter (
  input  logic        clk,
  input  logic        rst_n,
  vcsl_in_if.sink     in_ch,
  vcsl_out_if.source  out_ch,
  vcsl_cfg_if.sink    cfg_ch
);

  vcsl_pkg::cfg_t  cfg;
  vcsl_pkg::ctrl_t ctrl;
  vcsl_pkg::stat_t stat;

  vcsl_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  vcsl_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  vcsl_datapath u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .ctrl   (ctrl),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
